// File: hdl/lbr_pkg.sv
// Shared types and constants of the LED breathing ramp.
`default_nettype none
package lbr_pkg;

	typedef enum logic [1:0] {
		REQ_TICK    = 2'd0,
		REQ_SET     = 2'd1,
		REQ_REARM   = 2'd2,
		REQ_RESTART = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		CFG_LEVEL_MIN     = 3'd0,
		CFG_LEVEL_MAX     = 3'd1,
		CFG_RISE_STEP     = 3'd2,
		CFG_FALL_STEP     = 3'd3,
		CFG_RISE_DELAY    = 3'd4,
		CFG_FALL_DELAY    = 3'd5,
		CFG_START_FALLING = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0]  level_min;
		logic [7:0]  level_max;
		logic [7:0]  rise_step;
		logic [7:0]  fall_step;
		logic [15:0] rise_delay;
		logic [15:0] fall_delay;
		logic        start_falling;
	} cfg_t;

	typedef struct packed {
		logic [7:0] level;
		logic       falling;
		logic       armed;
	} ramp_state_t;

	typedef struct packed {
		logic       still_running;
		logic       now_falling;
		logic [7:0] brightness;
	} result_t;

	localparam int unsigned REARM_TICKS = 10;

	localparam cfg_t CFG_RESET = '{
		level_min:     8'd0,
		level_max:     8'd255,
		rise_step:     8'd5,
		fall_step:     8'd5,
		rise_delay:    16'd3,
		fall_delay:    16'd3,
		start_falling: 1'b1
	};

endpackage
`default_nettype wire

// File: hdl/lbr_step.sv
// Next-state and firing logic of the LED breathing ramp for one request.
`default_nettype none
module lbr_step #(
	parameter int unsigned LEVEL_MAX  = 255,
	parameter int unsigned DELAY_BITS = 16
) (
	input  lbr_pkg::cfg_t          cfg,
	input  lbr_pkg::ramp_state_t   st,
	input  logic [DELAY_BITS-1:0]  cnt,
	input  lbr_pkg::req_t          req,
	input  logic [7:0]             new_level,
	output lbr_pkg::ramp_state_t   st_nxt,
	output logic [DELAY_BITS-1:0]  cnt_nxt,
	output logic                   fire,
	output lbr_pkg::result_t       res
);
	import lbr_pkg::*;

	localparam logic [7:0]  LVL_TOP  = (LEVEL_MAX > 255) ? 8'd255 : 8'(LEVEL_MAX);
	localparam logic [32:0] CNT_MASK = (33'd1 << DELAY_BITS) - 33'd1;

	function automatic logic [7:0] cap_level(input logic [7:0] v);
		return (v > LVL_TOP) ? LVL_TOP : v;
	endfunction

	function automatic logic [DELAY_BITS-1:0] cap_count(input logic [31:0] v);
		logic [32:0] w;
		w = {1'b0, v};
		if (w > CNT_MASK)
			w = CNT_MASK;
		return w[DELAY_BITS-1:0];
	endfunction

	logic [7:0]            mn;
	logic [7:0]            mx;
	logic signed [9:0]     diff;
	logic [8:0]            sum;
	logic [7:0]            fired_level;
	logic                  fired_falling;
	logic [15:0]           delay;
	logic [DELAY_BITS-1:0] rearm_cnt;

	assign mn        = cap_level(cfg.level_min);
	assign mx        = cap_level(cfg.level_max);
	assign rearm_cnt = cap_count(32'(REARM_TICKS));

	// step and clamp for a firing
	always_comb begin
		diff          = $signed({2'b00, st.level}) - $signed({2'b00, cfg.fall_step});
		sum           = {1'b0, st.level} + {1'b0, cfg.rise_step};
		fired_level   = st.level;
		fired_falling = st.falling;
		if (st.falling) begin
			if (st.level != mn)
				fired_level = diff[7:0];
			if (st.level == mn || diff <= $signed({2'b00, mn})) begin
				fired_level   = mn;
				fired_falling = 1'b0;
			end
			delay = cfg.fall_delay;
		end else begin
			if (st.level != mx)
				fired_level = sum[7:0];
			if (st.level == mx || sum >= {1'b0, mx}) begin
				fired_level   = mx;
				fired_falling = 1'b1;
			end
			delay = cfg.rise_delay;
		end
	end

	always_comb begin
		st_nxt  = st;
		cnt_nxt = cnt;
		fire    = 1'b0;
		res     = '{still_running: (delay != 16'd0), now_falling: fired_falling,
		            brightness: st.level};
		unique case (req)
			REQ_TICK: begin
				if (st.armed) begin
					if (cnt <= DELAY_BITS'(1)) begin
						fire           = 1'b1;
						st_nxt.level   = fired_level;
						st_nxt.falling = fired_falling;
						st_nxt.armed   = (delay != 16'd0);
						cnt_nxt        = (delay != 16'd0) ? cap_count(32'(delay)) : '0;
					end else begin
						cnt_nxt = cnt - DELAY_BITS'(1);
					end
				end
			end
			REQ_SET: begin
				st_nxt.level = cap_level(new_level);
				st_nxt.armed = 1'b1;
				cnt_nxt      = rearm_cnt;
			end
			REQ_REARM: begin
				st_nxt.armed = 1'b1;
				cnt_nxt      = rearm_cnt;
			end
			REQ_RESTART: begin
				st_nxt.falling = cfg.start_falling;
				st_nxt.armed   = 1'b1;
				cnt_nxt        = rearm_cnt;
			end
			default: begin
				st_nxt = st;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: hdl/led_breathing_ramp.sv
// LED breathing ramp: one request per beat, a result beat on each firing.
// A request is registered at accept; its result beat is registered in the output register once the request advances.
// Throughput: one request per cycle, set by the combinational step and clamp on the
// request register; the request register stalls only while a result beat waits.
// Reset: level at the top bound, falling, countdown 1 and armed, so the first tick fires;
// configuration registers return to their documented defaults.
`default_nettype none
module led_breathing_ramp #(
	parameter int unsigned LEVEL_MAX  = 255,
	parameter int unsigned DELAY_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] new_level
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] brightness, [8] now_falling, [9] still_running
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import lbr_pkg::*;

	localparam logic [7:0] LVL_TOP = (LEVEL_MAX > 255) ? 8'd255 : 8'(LEVEL_MAX);

	cfg_t                  cfg_q;
	ramp_state_t           st_q;
	ramp_state_t           st_nxt;
	logic [DELAY_BITS-1:0] cnt_q;
	logic [DELAY_BITS-1:0] cnt_nxt;
	logic                  valid_s1;
	req_t                  req_s1;
	logic [7:0]            new_level_s1;
	logic                  fire;
	result_t               res;
	logic                  out_valid_q;
	result_t               out_q;
	logic                  out_free;
	logic                  advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_LEVEL_MIN:     cfg_q.level_min     <= cfg_data[7:0];
				CFG_LEVEL_MAX:     cfg_q.level_max     <= cfg_data[7:0];
				CFG_RISE_STEP:     cfg_q.rise_step     <= cfg_data[7:0];
				CFG_FALL_STEP:     cfg_q.fall_step     <= cfg_data[7:0];
				CFG_RISE_DELAY:    cfg_q.rise_delay    <= cfg_data;
				CFG_FALL_DELAY:    cfg_q.fall_delay    <= cfg_data;
				CFG_START_FALLING: cfg_q.start_falling <= cfg_data[0];
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	// hold the request while a result beat is still waiting downstream
	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1       <= req_t'(s_tuser);
			new_level_s1 <= s_tdata[7:0];
		end
	end

	lbr_step #(
		.LEVEL_MAX  (LEVEL_MAX),
		.DELAY_BITS (DELAY_BITS)
	) u_step (
		.cfg       (cfg_q),
		.st        (st_q),
		.cnt       (cnt_q),
		.req       (req_s1),
		.new_level (new_level_s1),
		.st_nxt    (st_nxt),
		.cnt_nxt   (cnt_nxt),
		.fire      (fire),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= '{level: LVL_TOP, falling: 1'b1, armed: 1'b1};
			cnt_q <= DELAY_BITS'(1);
		end else if (advance) begin
			st_q  <= st_nxt;
			cnt_q <= cnt_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_free)
			out_valid_q <= advance && fire;
	end

	always_ff @(posedge clk) begin
		if (advance && fire)
			out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_q.still_running, out_q.now_falling, out_q.brightness};

endmodule
`default_nettype wire
